>>> hdl/ffpra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_pkg
// Shared types and codes for the first-fit page region allocator.
// ----------------------------------------------------------------------------
package ffpra_pkg;

  localparam int ADDR_W    = 48;
  localparam int REQ_W     = 32;
  localparam int TYPE_W    = 4;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 7;
  localparam int INVALID_W = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_EMPTY      = 3'd1,
    STAT_MISALIGNED = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_NOFIT      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLS_DEVICE = 2'd0,
    CLS_USED   = 2'd1,
    CLS_FREE   = 2'd2
  } class_t;

  localparam logic [TYPE_W-1:0] FW_FREE = 4'd1;
  localparam logic [TYPE_W-1:0] FW_ACPI = 4'd2;
  localparam logic [TYPE_W-1:0] FW_MMIO = 4'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  function automatic class_t class_of(input logic [TYPE_W-1:0] fw_type);
    class_t c;
    case (fw_type) inside
      FW_FREE:          c = CLS_FREE;
      FW_ACPI, FW_MMIO: c = CLS_DEVICE;
      default:          c = CLS_USED;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ffpra_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_alu
// Shared add/subtract unit; carry is the borrow on subtract.
// ----------------------------------------------------------------------------
module ffpra_alu #(
  parameter int W = 40
) (
  input  wire ffpra_pkg::alu_op_t op,
  input  wire logic [W-1:0]       a,
  input  wire logic [W-1:0]       b,
  output logic      [W-1:0]       res,
  output logic                    carry
);

  logic [W:0] full;

  always_comb begin
    unique case (op)
      ffpra_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ffpra_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default:            full = '0;
    endcase
  end

  assign res   = full[W-1:0];
  assign carry = full[W];

endmodule
`default_nettype wire

>>> hdl/ffpra_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffpra_table
// Region table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffpra_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 74
) (
  input  wire  logic          clk,
  input  wire  logic          we,
  input  wire  logic [AW-1:0] waddr,
  input  wire  logic [DW-1:0] wdata,
  input  wire  logic [AW-1:0] raddr,
  output logic       [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/first_fit_page_region_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_region_allocator_core
// First-fit allocator over a table of memory regions kept in page units.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. in_cmd selects
//   a region load or a page allocation. Exactly one result follows, shown
//   for one cycle with out_valid high; the receiver cannot stall it.
//   Steps:
//     load          : result in the cycle after the request.
//     alloc, no scan: as for a load (zero request or empty table).
//     alloc         : scan the entries in order (one table read per
//                     cycle, shared subtractor compares size), then
//                     form the address and, when the region is used
//                     up, shift the entries above it down, one table
//                     write per cycle.
//   Requests are handled one at a time; the next one can be taken in the
//   cycle the result is shown. Loads never raise busy; a scanning alloc
//   holds busy high from the cycle after the request until that cycle.
//   Reset clears the entry count and the misaligned counter; the table
//   itself needs no clearing, since only entries below the count are used.
// ----------------------------------------------------------------------------
module first_fit_page_region_allocator_core #(
  parameter int MAX_REGIONS = 64,
  parameter int PAGE_BYTES  = 4096
) (
  input  wire  logic                               clk,
  input  wire  logic                               rst_n,
  input  wire  logic                               start,
  output logic                                     busy,
  input  wire  logic                               in_cmd,
  input  wire  logic [ffpra_pkg::ADDR_W-1:0]       in_region_base,
  input  wire  logic [ffpra_pkg::ADDR_W-1:0]       in_region_bytes,
  input  wire  logic [ffpra_pkg::TYPE_W-1:0]       in_region_type,
  input  wire  logic [ffpra_pkg::REQ_W-1:0]        in_req_pages,
  output logic                                     out_valid,
  output logic       [ffpra_pkg::STATUS_W-1:0]     out_status,
  output logic       [ffpra_pkg::ADDR_W-1:0]       out_alloc_addr,
  output logic       [ffpra_pkg::COUNT_W-1:0]      out_region_count,
  output logic       [ffpra_pkg::INVALID_W-1:0]    out_invalid_count
);

  localparam int PG_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W     = ffpra_pkg::ADDR_W - PG_SHIFT;
  localparam int IDX_W    = $clog2(MAX_REGIONS);
  localparam int CNT_W    = $clog2(MAX_REGIONS + 1);
  localparam int ENT_W    = 2 * PG_W + 2;
  localparam int AW       = ((PG_W > ffpra_pkg::REQ_W) ? PG_W : ffpra_pkg::REQ_W) + 1;
  localparam logic [ffpra_pkg::INVALID_W-1:0] INV_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ADDR,
    S_DROP
  } state_t;

  state_t                             state_r, state_nxt;
  logic [CNT_W-1:0]                   total_r, total_nxt;
  logic [ffpra_pkg::INVALID_W-1:0]    inval_r, inval_nxt;
  logic [ffpra_pkg::REQ_W-1:0]        req_r, req_nxt;
  logic [CNT_W-1:0]                   idx_r, idx_nxt;
  logic [CNT_W-1:0]                   chk_r, chk_nxt;
  logic                               rv_r, rv_nxt;
  logic [IDX_W-1:0]                   hit_r, hit_nxt;
  logic [PG_W-1:0]                    rem_r, rem_nxt;
  logic [PG_W-1:0]                    hbase_r, hbase_nxt;
  logic [CNT_W-1:0]                   w_r, w_nxt;
  logic [ffpra_pkg::ADDR_W-1:0]       addr_r, addr_nxt;
  logic                               out_valid_r, out_valid_nxt;
  ffpra_pkg::status_t                 out_status_r, out_status_nxt;
  logic [ffpra_pkg::ADDR_W-1:0]       out_addr_r, out_addr_nxt;
  logic [ffpra_pkg::COUNT_W-1:0]      out_count_r, out_count_nxt;
  logic [ffpra_pkg::INVALID_W-1:0]    out_inval_r, out_inval_nxt;

  logic                               mem_we;
  logic [IDX_W-1:0]                   mem_waddr;
  logic [ENT_W-1:0]                   mem_wdata;
  logic [IDX_W-1:0]                   mem_raddr;
  logic [ENT_W-1:0]                   mem_rdata;

  ffpra_pkg::alu_op_t                 alu_op;
  logic [AW-1:0]                      alu_a, alu_b, alu_res;
  logic                               alu_carry;

  logic [PG_W-1:0]                    rd_base, rd_pages;
  ffpra_pkg::class_t                  rd_class;
  logic                               accept;
  logic                               misaligned;

  ffpra_table #(
    .DEPTH (MAX_REGIONS),
    .AW    (IDX_W),
    .DW    (ENT_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffpra_alu #(
    .W (AW)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  assign rd_base  = mem_rdata[ENT_W-1 -: PG_W];
  assign rd_pages = mem_rdata[PG_W+1 -: PG_W];
  assign rd_class = ffpra_pkg::class_t'(mem_rdata[1:0]);

  assign accept     = start && (state_r == S_IDLE);
  assign misaligned = (in_region_base[PG_SHIFT-1:0] != '0) ||
                      (in_region_bytes[PG_SHIFT-1:0] != '0);

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    inval_nxt      = inval_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    chk_nxt        = chk_r;
    rv_nxt         = rv_r;
    hit_nxt        = hit_r;
    rem_nxt        = rem_r;
    hbase_nxt      = hbase_r;
    w_nxt          = w_r;
    addr_nxt       = addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = '0;
    out_count_nxt  = out_count_r;
    out_inval_nxt  = out_inval_r;

    mem_we    = 1'b0;
    mem_waddr = total_r[IDX_W-1:0];
    mem_wdata = {in_region_base[ffpra_pkg::ADDR_W-1:PG_SHIFT],
                 in_region_bytes[ffpra_pkg::ADDR_W-1:PG_SHIFT],
                 ffpra_pkg::class_of(in_region_type)};
    mem_raddr = idx_r[IDX_W-1:0];

    alu_op = ffpra_pkg::ALU_SUB;
    alu_a  = AW'(rd_pages);
    alu_b  = AW'(req_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == ffpra_pkg::CMD_LOAD) begin
            out_valid_nxt = 1'b1;
            if (in_region_bytes == '0) begin
              out_status_nxt = ffpra_pkg::STAT_EMPTY;
            end else if (misaligned) begin
              out_status_nxt = ffpra_pkg::STAT_MISALIGNED;
              if (inval_r != INV_MAX) begin
                inval_nxt = inval_r + 1'b1;
              end
            end else if (total_r == CNT_W'(MAX_REGIONS)) begin
              out_status_nxt = ffpra_pkg::STAT_FULL;
            end else begin
              out_status_nxt = ffpra_pkg::STAT_OK;
              mem_we         = 1'b1;
              total_nxt      = total_r + 1'b1;
            end
            out_count_nxt = ffpra_pkg::COUNT_W'(total_nxt);
            out_inval_nxt = inval_nxt;
          end else if (in_req_pages == '0 || total_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ffpra_pkg::STAT_NOFIT;
            out_count_nxt  = ffpra_pkg::COUNT_W'(total_r);
            out_inval_nxt  = inval_r;
          end else begin
            req_nxt   = in_req_pages;
            idx_nxt   = '0;
            rv_nxt    = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (rv_r && rd_class == ffpra_pkg::CLS_FREE && !alu_carry) begin
          hit_nxt   = chk_r[IDX_W-1:0];
          rem_nxt   = alu_res[PG_W-1:0];
          hbase_nxt = rd_base;
          state_nxt = S_ADDR;
        end else if (rv_r && chk_r == total_r - 1'b1) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ffpra_pkg::STAT_NOFIT;
          out_count_nxt  = ffpra_pkg::COUNT_W'(total_r);
          out_inval_nxt  = inval_r;
          state_nxt      = S_IDLE;
        end else begin
          rv_nxt  = (idx_r < total_r);
          chk_nxt = idx_r;
          if (idx_r < total_r) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_ADDR: begin
        alu_op   = ffpra_pkg::ALU_ADD;
        alu_a    = AW'(hbase_r);
        alu_b    = AW'(rem_r);
        addr_nxt = {alu_res[PG_W-1:0], {PG_SHIFT{1'b0}}};
        if (rem_r == '0) begin
          mem_raddr = hit_r + 1'b1;
          w_nxt     = CNT_W'(hit_r);
          state_nxt = S_DROP;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = hit_r;
          mem_wdata      = {hbase_r, rem_r, ffpra_pkg::CLS_FREE};
          out_valid_nxt  = 1'b1;
          out_status_nxt = ffpra_pkg::STAT_OK;
          out_addr_nxt   = addr_nxt;
          out_count_nxt  = ffpra_pkg::COUNT_W'(total_r);
          out_inval_nxt  = inval_r;
          state_nxt      = S_IDLE;
        end
      end

      S_DROP: begin
        mem_raddr = IDX_W'(w_r + CNT_W'(2));
        if (w_r + 1'b1 < total_r) begin
          mem_we    = 1'b1;
          mem_waddr = w_r[IDX_W-1:0];
          mem_wdata = mem_rdata;
          w_nxt     = w_r + 1'b1;
        end else begin
          total_nxt      = total_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ffpra_pkg::STAT_OK;
          out_addr_nxt   = addr_r;
          out_count_nxt  = ffpra_pkg::COUNT_W'(total_nxt);
          out_inval_nxt  = inval_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      inval_r     <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      inval_r     <= inval_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    chk_r        <= chk_nxt;
    hit_r        <= hit_nxt;
    rem_r        <= rem_nxt;
    hbase_r      <= hbase_nxt;
    w_r          <= w_nxt;
    addr_r       <= addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_count_r  <= out_count_nxt;
    out_inval_r  <= out_inval_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_alloc_addr    = out_addr_r;
  assign out_region_count  = out_count_r;
  assign out_invalid_count = out_inval_r;

endmodule
`default_nettype wire

>>> dv/first_fit_page_region_allocator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_page_region_allocator_core_tb
// Self-checking bench for the first-fit page region allocator. A directed
// table covers empty, misaligned, device/used/free loads, zero and oversized
// requests, exact-fit removal and address wrap; random phases with varying
// load/alloc mix and sender gaps follow. Each result is checked against
// the row's given values where known, else the bench's page-table shadow.
// ----------------------------------------------------------------------------
module first_fit_page_region_allocator_core_tb;

  localparam int MAX_REGIONS = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int RAND_PER_PHASE = 310;
  localparam int ADDR_W    = ffpra_pkg::ADDR_W;
  localparam int TYPE_W    = ffpra_pkg::TYPE_W;
  localparam int REQ_W     = ffpra_pkg::REQ_W;
  localparam int STATUS_W  = ffpra_pkg::STATUS_W;
  localparam int COUNT_W   = ffpra_pkg::COUNT_W;
  localparam int INVALID_W = ffpra_pkg::INVALID_W;

  typedef struct {
    logic                cmd;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   bytes;
    logic [TYPE_W-1:0]   rtype;
    logic [REQ_W-1:0]    req;
  } request_t;

  typedef struct {
    ffpra_pkg::status_t   status;
    logic [ADDR_W-1:0]    addr;
    logic [COUNT_W-1:0]   count;
    logic [INVALID_W-1:0] invalid;
  } outcome_t;

  typedef struct {
    request_t rq;
    bit       known;
    outcome_t exp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_cmd;
  logic [ADDR_W-1:0] in_region_base;
  logic [ADDR_W-1:0] in_region_bytes;
  logic [TYPE_W-1:0] in_region_type;
  logic [REQ_W-1:0] in_req_pages;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0] out_alloc_addr;
  logic [COUNT_W-1:0] out_region_count;
  logic [INVALID_W-1:0] out_invalid_count;

  // shadow of the region table
  logic [35:0] tbl_base_pg [MAX_REGIONS];
  logic [35:0] tbl_pages [MAX_REGIONS];
  ffpra_pkg::class_t tbl_class [MAX_REGIONS];
  int tbl_count;
  logic [INVALID_W-1:0] misaligned_cnt;

  outcome_t pending_results[$];
  dir_row_t directed_rows[$];
  int error_count;

  first_fit_page_region_allocator_core #(
    .MAX_REGIONS(MAX_REGIONS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_region_base   (in_region_base),
    .in_region_bytes  (in_region_bytes),
    .in_region_type   (in_region_type),
    .in_req_pages     (in_req_pages),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_alloc_addr   (out_alloc_addr),
    .out_region_count (out_region_count),
    .out_invalid_count(out_invalid_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [ADDR_W-1:0] rnd48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[ADDR_W-1:0];
  endfunction

  task automatic predict_request(input request_t r, output outcome_t o);
    int idx;
    int j;
    bit hit;
    logic [63:0] pg;
    o.status = ffpra_pkg::STAT_OK;
    o.addr = '0;
    hit = 1'b0;
    if (r.cmd == ffpra_pkg::CMD_LOAD) begin
      if (r.bytes == 0) begin
        o.status = ffpra_pkg::STAT_EMPTY;
      end else if (r.bytes % ADDR_W'(PAGE_BYTES) != 0 ||
                   r.base % ADDR_W'(PAGE_BYTES) != 0) begin
        o.status = ffpra_pkg::STAT_MISALIGNED;
        if (misaligned_cnt != '1) misaligned_cnt++;
      end else if (tbl_count >= MAX_REGIONS) begin
        o.status = ffpra_pkg::STAT_FULL;
      end else begin
        tbl_base_pg[tbl_count] = 36'(r.base / ADDR_W'(PAGE_BYTES));
        tbl_pages[tbl_count] = 36'(r.bytes / ADDR_W'(PAGE_BYTES));
        case (r.rtype)
          ffpra_pkg::FW_FREE: tbl_class[tbl_count] = ffpra_pkg::CLS_FREE;
          ffpra_pkg::FW_ACPI, ffpra_pkg::FW_MMIO:
            tbl_class[tbl_count] = ffpra_pkg::CLS_DEVICE;
          default: tbl_class[tbl_count] = ffpra_pkg::CLS_USED;
        endcase
        tbl_count++;
      end
    end else begin
      o.status = ffpra_pkg::STAT_NOFIT;
      if (r.req != 0) begin
        for (idx = 0; idx < tbl_count && !hit; idx++) begin
          if (tbl_class[idx] == ffpra_pkg::CLS_FREE &&
              64'(tbl_pages[idx]) >= 64'(r.req)) begin
            hit = 1'b1;
            o.status = ffpra_pkg::STAT_OK;
            pg = 64'(tbl_base_pg[idx]) + 64'(tbl_pages[idx]) - 64'(r.req);
            o.addr = ADDR_W'(pg * 64'(PAGE_BYTES));
            if (64'(tbl_pages[idx]) == 64'(r.req)) begin
              for (j = idx; j + 1 < tbl_count; j++) begin
                tbl_base_pg[j] = tbl_base_pg[j+1];
                tbl_pages[j] = tbl_pages[j+1];
                tbl_class[j] = tbl_class[j+1];
              end
              tbl_count--;
            end else begin
              tbl_pages[idx] = tbl_pages[idx] - 36'(r.req);
            end
          end
        end
      end
    end
    o.count = COUNT_W'(tbl_count);
    o.invalid = misaligned_cnt;
  endtask

  function automatic request_t random_request(input int load_pct);
    request_t r;
    int sel;
    int k;
    int j;
    int m;
    bit found;
    logic [63:0] v;
    logic [35:0] bp;
    r.cmd = ($urandom_range(99) < load_pct) ? ffpra_pkg::CMD_LOAD : ffpra_pkg::CMD_ALLOC;
    r.base = rnd48();
    r.bytes = rnd48();
    r.rtype = ($urandom_range(1) == 0) ? ffpra_pkg::FW_FREE : TYPE_W'($urandom_range(15));
    r.req = $urandom();
    sel = $urandom_range(99);
    if (r.cmd == ffpra_pkg::CMD_LOAD) begin
      if (sel < 8) begin
        r.bytes = '0;
      end else if (sel < 18) begin
        if (r.bytes == 0 || (r.bytes % ADDR_W'(PAGE_BYTES) == 0 &&
                             r.base % ADDR_W'(PAGE_BYTES) == 0))
          r.bytes = r.bytes | ADDR_W'(1);
      end else if (sel < 22) begin
        r.base = r.base - r.base % ADDR_W'(PAGE_BYTES);
        r.bytes = r.bytes - r.bytes % ADDR_W'(PAGE_BYTES);
        if (r.bytes == 0) r.bytes = ADDR_W'(PAGE_BYTES);
      end else begin
        v = {$urandom(), $urandom()};
        bp = ($urandom_range(1) == 0) ? 36'($urandom_range(4095)) : v[35:0];
        r.base = ADDR_W'(bp) * ADDR_W'(PAGE_BYTES);
        r.bytes = ADDR_W'($urandom_range(1, 64)) * ADDR_W'(PAGE_BYTES);
      end
    end else begin
      if (sel < 5) begin
        r.req = '0;
      end else if (sel < 12) begin
        r.req = $urandom();
      end else if (sel < 50 && tbl_count > 0) begin
        found = 1'b0;
        k = $urandom_range(tbl_count - 1);
        for (j = 0; j < tbl_count; j++) begin
          m = (k + j) % tbl_count;
          if (!found && tbl_class[m] == ffpra_pkg::CLS_FREE) begin
            found = 1'b1;
            r.req = (tbl_pages[m] > 36'hFFFF_FFFF) ? $urandom() : REQ_W'(tbl_pages[m]);
          end
        end
        if (!found) r.req = $urandom_range(1, 24);
      end else begin
        r.req = $urandom_range(1, 24);
      end
    end
    return r;
  endfunction

  // drive one request, wait for it to be taken, queue its expected result
  task automatic issue(input request_t r, input int idle_pct, input bit known,
                       input outcome_t typed);
    outcome_t o;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= r.cmd;
    in_region_base <= r.base;
    in_region_bytes <= r.bytes;
    in_region_type <= r.rtype;
    in_req_pages <= r.req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(r, o);
    pending_results.push_back(known ? typed : o);
  endtask

  function automatic dir_row_t mk_row(input logic cmd, input logic [ADDR_W-1:0] base,
                                      input logic [ADDR_W-1:0] bytes,
                                      input logic [TYPE_W-1:0] rtype,
                                      input logic [REQ_W-1:0] req, input bit known,
                                      input ffpra_pkg::status_t st,
                                      input logic [ADDR_W-1:0] addr,
                                      input int cnt, input int inv);
    dir_row_t d;
    d.rq.cmd = cmd;
    d.rq.base = base;
    d.rq.bytes = bytes;
    d.rq.rtype = rtype;
    d.rq.req = req;
    d.known = known;
    d.exp.status = st;
    d.exp.addr = addr;
    d.exp.count = COUNT_W'(cnt);
    d.exp.invalid = INVALID_W'(inv);
    return d;
  endfunction

  task automatic note_error(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    error_count++;
    $display("%0t %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    outcome_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_error("result with no request outstanding", 64'd0, 64'(out_status));
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) note_error("status", 64'(e.status), 64'(out_status));
        if (out_alloc_addr !== e.addr) note_error("alloc_addr", 64'(e.addr), 64'(out_alloc_addr));
        if (out_region_count !== e.count)
          note_error("region_count", 64'(e.count), 64'(out_region_count));
        if (out_invalid_count !== e.invalid)
          note_error("invalid_count", 64'(e.invalid), 64'(out_invalid_count));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stim
    request_t r;
    outcome_t none;
    int ph;
    int n;
    int idle_pct;
    int load_pct;
    none.status = ffpra_pkg::STAT_OK;
    none.addr = '0;
    none.count = '0;
    none.invalid = '0;
    error_count = 0;
    tbl_count = 0;
    misaligned_cnt = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = ffpra_pkg::CMD_LOAD;
    in_region_base = '0;
    in_region_bytes = '0;
    in_region_type = '0;
    in_req_pages = '0;

    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 1, 1,
                                   ffpra_pkg::STAT_NOFIT, 0, 0, 0));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'h5000, 0, ffpra_pkg::FW_FREE, 0, 1,
                                   ffpra_pkg::STAT_EMPTY, 0, 0, 0));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'h1001, 48'h1000,
                                   ffpra_pkg::FW_FREE, 0, 1,
                                   ffpra_pkg::STAT_MISALIGNED, 0, 0, 1));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 0, 48'h1800, ffpra_pkg::FW_FREE, 0, 1,
                                   ffpra_pkg::STAT_MISALIGNED, 0, 0, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'hFFFF_FFFF_F000, 48'h2000,
                                   ffpra_pkg::FW_FREE, 0, 1,
                                   ffpra_pkg::STAT_OK, 0, 1, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 0, 1,
                                   ffpra_pkg::STAT_NOFIT, 0, 1, 2));
    // top page sits past the 48-bit space, address wraps to zero
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 1, 1,
                                   ffpra_pkg::STAT_OK, 0, 1, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 1, 1, ffpra_pkg::STAT_OK,
                                   48'hFFFF_FFFF_F000, 0, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 0, 48'h1000, 4'd0, 0, 1,
                                   ffpra_pkg::STAT_OK, 0, 1, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'h10_0000, 48'h4000,
                                   ffpra_pkg::FW_ACPI, 0, 1,
                                   ffpra_pkg::STAT_OK, 0, 2, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'h11_0000, 48'h4000,
                                   ffpra_pkg::FW_MMIO, 0, 1,
                                   ffpra_pkg::STAT_OK, 0, 3, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'h12_0000, 48'h4000, 4'd15, 0, 1,
                                   ffpra_pkg::STAT_OK, 0, 4, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'h20_0000, 48'h8000,
                                   ffpra_pkg::FW_FREE, 0, 1,
                                   ffpra_pkg::STAT_OK, 0, 5, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 9, 1,
                                   ffpra_pkg::STAT_NOFIT, 0, 5, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 32'hFFFF_FFFF, 1,
                                   ffpra_pkg::STAT_NOFIT, 0, 5, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 3, 1,
                                   ffpra_pkg::STAT_OK, 48'h20_5000, 5, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'h30_0000, 48'hFFFF_FFFF_F000,
                                   ffpra_pkg::FW_FREE, 0, 1,
                                   ffpra_pkg::STAT_OK, 0, 6, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 6, 0,
                                   ffpra_pkg::STAT_OK, 0, 0, 0));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 5, 1,
                                   ffpra_pkg::STAT_OK, 48'h20_0000, 5, 2));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                   4'd7, 0, 1, ffpra_pkg::STAT_MISALIGNED, 0, 5, 3));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 0, 48'hFFFF_FFFF_FFFF, 4'd15, 0, 1,
                                   ffpra_pkg::STAT_MISALIGNED, 0, 5, 4));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_ALLOC, 0, 0, 0, 32'hFFFF_FFFF, 0,
                                   ffpra_pkg::STAT_OK, 0, 0, 0));
    directed_rows.push_back(mk_row(ffpra_pkg::CMD_LOAD, 48'h40_0000, 48'h1000, 4'd4, 0, 0,
                                   ffpra_pkg::STAT_OK, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].rq, 24, directed_rows[i].known, directed_rows[i].exp);

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 24 : (ph == 1) ? 76 : 0;
      load_pct = (ph == 0) ? 65 : (ph == 1) ? 35 : 50;
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        r = random_request(load_pct);
        issue(r, idle_pct, 1'b0, none);
      end
      // hold off until the block has drained
      start <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
      @(posedge clk);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * MAX_REGIONS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
